// ===== design/cfq_pkg.sv =====
// Shared constants, types and helpers for the circular FIFO queue.
package cfq_pkg;

    localparam int DEPTH            = 16;
    localparam int WORD_BITS        = 32;
    localparam int PTR_BITS         = $clog2(DEPTH);
    localparam int CNT_BITS         = $clog2(DEPTH + 1);
    localparam int ACTION_BITS      = 3;
    localparam int STATUS_BITS      = 2;
    localparam int COUNT_FIELD_BITS = 5;
    localparam int TDATA_BITS       = 40;
    localparam int TDATA_PAD_BITS   = TDATA_BITS - WORD_BITS - COUNT_FIELD_BITS;

    typedef logic [PTR_BITS-1:0]  ptr_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;
    typedef logic [WORD_BITS-1:0] word_t;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_APPEND   = 3'd0,
        ACT_SERVE    = 3'd1,
        ACT_SIZE     = 3'd2,
        ACT_CLEAR    = 3'd3,
        ACT_TRAVERSE = 3'd4
    } action_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Wrap on the pointer itself; DEPTH need not be a power of two.
    function automatic ptr_t ptr_advance(input ptr_t p);
        ptr_t r;
        if (p == ptr_t'(DEPTH - 1))
            r = '0;
        else
            r = p + ptr_t'(1);
        return r;
    endfunction

endpackage

// ===== design/cfq_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
module cfq_ram #(
    parameter int DEPTH_P = 16,
    parameter int WIDTH_P = 32,
    parameter int ADDR_BITS_P = $clog2(DEPTH_P)
) (
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [ADDR_BITS_P-1:0] wr_addr,
    input  logic [WIDTH_P-1:0]     wr_data,
    input  logic [ADDR_BITS_P-1:0] rd_addr,
    output logic [WIDTH_P-1:0]     rd_data
);

    logic [WIDTH_P-1:0] mem [DEPTH_P];
    logic [WIDTH_P-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/circular_fifo_queue_unit.sv =====
// Circular FIFO queue: pointer/count control, slot RAM and output register.
// Append, size, clear and unused codes give their beat in the cycle after accept; serve and
//   the first traverse beat pass through the slot RAM read register, then the output register.
// New actions are taken only in idle with the output free, so serve and traverse hold off the
//   next action until done; a non-empty traverse does one slot RAM read per stored word.
// Reset clears head, tail, count, state and output valid; slot RAM contents are not cleared.
module circular_fifo_queue_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] entry_value
    input  logic [2:0]  s_tuser,   // [2:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] data_out, [36:32] count_out, [39:37] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SERVE = 3'b010,
        S_WALK  = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    cfq_pkg::ptr_t     head_reg, head_next;
    cfq_pkg::ptr_t     tail_reg, tail_next;
    cfq_pkg::cnt_t     fill_reg, fill_next;
    cfq_pkg::ptr_t     walk_ptr_reg, walk_ptr_next;
    cfq_pkg::cnt_t     walk_left_reg, walk_left_next;

    logic              m_valid_reg, m_valid_next;
    cfq_pkg::status_t  out_status_reg, out_status_next;
    cfq_pkg::word_t    out_data_reg, out_data_next;
    cfq_pkg::cnt_t     out_count_reg, out_count_next;
    logic              out_last_reg, out_last_next;

    logic              out_free;
    logic              accept;
    logic              is_empty;
    logic              is_full;
    logic              wr_en;
    cfq_pkg::ptr_t     rd_addr;
    cfq_pkg::word_t    rd_data;
    cfq_pkg::action_t  action;

    cfq_ram #(
        .DEPTH_P (cfq_pkg::DEPTH),
        .WIDTH_P (cfq_pkg::WORD_BITS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (s_tdata),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign action   = cfq_pkg::action_t'(s_tuser);
    assign is_empty = (fill_reg == '0);
    assign is_full  = (fill_reg == cfq_pkg::cnt_t'(cfq_pkg::DEPTH));

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        fill_next       = fill_reg;
        walk_ptr_next   = walk_ptr_reg;
        walk_left_next  = walk_left_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;
        wr_en           = 1'b0;
        rd_addr         = head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    m_valid_next    = 1'b1;
                    out_status_next = cfq_pkg::ST_OK;
                    out_data_next   = '0;
                    out_count_next  = fill_reg;
                    out_last_next   = 1'b1;
                    unique case (action)
                        cfq_pkg::ACT_APPEND:
                        begin
                            if (is_full)
                            begin
                                out_status_next = cfq_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en          = 1'b1;
                                tail_next      = cfq_pkg::ptr_advance(tail_reg);
                                fill_next      = fill_reg + cfq_pkg::cnt_t'(1);
                                out_count_next = fill_reg + cfq_pkg::cnt_t'(1);
                            end
                        end
                        cfq_pkg::ACT_SERVE:
                        begin
                            if (is_empty)
                            begin
                                out_status_next = cfq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                // beat goes out once the head word is read
                                m_valid_next = 1'b0;
                                head_next    = cfq_pkg::ptr_advance(head_reg);
                                fill_next    = fill_reg - cfq_pkg::cnt_t'(1);
                                state_next   = S_SERVE;
                            end
                        end
                        cfq_pkg::ACT_SIZE:
                        begin
                            if (is_empty)
                            begin
                                out_status_next = cfq_pkg::ST_EMPTY;
                            end
                        end
                        cfq_pkg::ACT_CLEAR:
                        begin
                            if (is_empty)
                            begin
                                out_status_next = cfq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                head_next      = '0;
                                tail_next      = '0;
                                fill_next      = '0;
                                out_count_next = '0;
                            end
                        end
                        cfq_pkg::ACT_TRAVERSE:
                        begin
                            if (is_empty)
                            begin
                                out_status_next = cfq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                m_valid_next   = 1'b0;
                                walk_ptr_next  = head_reg;
                                walk_left_next = fill_reg;
                                state_next     = S_WALK;
                            end
                        end
                        default:
                        begin
                            out_status_next = cfq_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_SERVE:
            begin
                // output register was drained at accept, so it is free here
                m_valid_next    = 1'b1;
                out_status_next = cfq_pkg::ST_OK;
                out_data_next   = rd_data;
                out_count_next  = fill_reg;
                out_last_next   = 1'b1;
                state_next      = S_IDLE;
            end
            S_WALK:
            begin
                rd_addr = walk_ptr_reg;
                if (out_free)
                begin
                    m_valid_next    = 1'b1;
                    out_status_next = cfq_pkg::ST_OK;
                    out_data_next   = rd_data;
                    out_count_next  = fill_reg;
                    out_last_next   = (walk_left_reg == cfq_pkg::cnt_t'(1));
                    walk_ptr_next   = cfq_pkg::ptr_advance(walk_ptr_reg);
                    walk_left_next  = walk_left_reg - cfq_pkg::cnt_t'(1);
                    // prefetch the next slot so data is ready on the following cycle
                    rd_addr         = cfq_pkg::ptr_advance(walk_ptr_reg);
                    if (walk_left_reg == cfq_pkg::cnt_t'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            walk_ptr_reg  <= '0;
            walk_left_reg <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            walk_ptr_reg  <= walk_ptr_next;
            walk_left_reg <= walk_left_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{cfq_pkg::TDATA_PAD_BITS{1'b0}},
                       cfq_pkg::COUNT_FIELD_BITS'(out_count_reg),
                       out_data_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== verif/circular_fifo_queue_unit_tb.sv =====
// Self-checking testbench for the circular FIFO queue unit: table-driven and random actions.
`timescale 1ns / 100ps

module circular_fifo_queue_unit_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_STALL = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS = 130;
    localparam int NUM_ROWS = 17;
    localparam logic [cfq_pkg::ACTION_BITS-1:0] ACT_SPARE_LO = 3'd5;
    localparam logic [cfq_pkg::ACTION_BITS-1:0] ACT_SPARE_MID = 3'd6;
    localparam logic [cfq_pkg::ACTION_BITS-1:0] ACT_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [cfq_pkg::STATUS_BITS-1:0]      status;
        cfq_pkg::word_t                       data;
        logic [cfq_pkg::COUNT_FIELD_BITS-1:0] count;
        logic                                 last;
    } beat_t;

    typedef struct {
        logic [cfq_pkg::ACTION_BITS-1:0] act;
        cfq_pkg::word_t                  val;
        int                              reps;
        bit                              typed;
        beat_t                           res;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // [31:0] entry_value
    logic [2:0]  s_tuser = '0;   // [2:0] action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // [31:0] data_out, [36:32] count_out, [39:37] zero
    logic [1:0]  m_tuser;        // [1:0] status
    logic        m_tlast;

    // queue shadow state
    cfq_pkg::word_t ring [cfq_pkg::DEPTH];
    cfq_pkg::ptr_t  rd_ptr = '0;
    cfq_pkg::ptr_t  wr_ptr = '0;
    cfq_pkg::cnt_t  fill = '0;

    beat_t     expect_q [$];
    stim_row_t dir_tab [NUM_ROWS];
    int        err_count = 0;
    int        quiet_cycles = 0;
    int        stall_left = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;

    circular_fifo_queue_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    function automatic cfq_pkg::ptr_t next_slot(input cfq_pkg::ptr_t p);
        return (p == cfq_pkg::ptr_t'(cfq_pkg::DEPTH - 1)) ? cfq_pkg::ptr_t'(0)
                                                           : cfq_pkg::ptr_t'(p + 1'b1);
    endfunction

    // Advance the shadow queue by one action; queue the beats it should produce when keep is set.
    function automatic void queue_step(input logic [cfq_pkg::ACTION_BITS-1:0] act,
                                       input cfq_pkg::word_t val, input bit keep);
        beat_t         b;
        cfq_pkg::ptr_t p;
        int            n;
        b = '{cfq_pkg::ST_OK, '0, '0, 1'b1};
        case (act)
            cfq_pkg::ACT_APPEND:
            begin
                if (fill == cfq_pkg::cnt_t'(cfq_pkg::DEPTH))
                    b.status = cfq_pkg::ST_FULL;
                else
                begin
                    ring[wr_ptr] = val;
                    wr_ptr = next_slot(wr_ptr);
                    fill = fill + 1'b1;
                end
                b.count = fill;
            end
            cfq_pkg::ACT_SERVE:
            begin
                if (fill == 0)
                    b.status = cfq_pkg::ST_EMPTY;
                else
                begin
                    b.data = ring[rd_ptr];
                    rd_ptr = next_slot(rd_ptr);
                    fill = fill - 1'b1;
                    b.count = fill;
                end
            end
            cfq_pkg::ACT_SIZE:
            begin
                b.status = (fill == 0) ? cfq_pkg::ST_EMPTY : cfq_pkg::ST_OK;
                b.count = fill;
            end
            cfq_pkg::ACT_CLEAR:
            begin
                if (fill == 0)
                    b.status = cfq_pkg::ST_EMPTY;
                rd_ptr = '0;
                wr_ptr = '0;
                fill = '0;
            end
            cfq_pkg::ACT_TRAVERSE:
            begin
                if (fill == 0)
                    b.status = cfq_pkg::ST_EMPTY;
                else
                begin
                    // one beat per stored word, oldest first, queue left as is
                    p = rd_ptr;
                    n = int'(fill);
                    for (int k = 0; k < n; k++)
                    begin
                        b.data = ring[p];
                        b.count = fill;
                        b.last = (k == n - 1);
                        if (keep)
                            expect_q.push_back(b);
                        p = next_slot(p);
                    end
                    return;
                end
            end
            default:
                b.count = fill;
        endcase
        if (keep)
            expect_q.push_back(b);
    endfunction

    task automatic report_beat(input string what, input beat_t want, input beat_t got);
        err_count++;
        if (err_count <= 10)
            $display({"%0t %s: expected st=%0d data=%h cnt=%0d last=%0d,",
                      " got st=%0d data=%h cnt=%0d last=%0d"},
                     $realtime, what, want.status, want.data, want.count, want.last,
                     got.status, got.data, got.count, got.last);
    endtask

    // Called on a rising edge; returns on the edge where the beat is taken.
    task automatic send_action(input logic [cfq_pkg::ACTION_BITS-1:0] act,
                               input cfq_pkg::word_t val, input bit typed, input beat_t res);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= val;
        do @(posedge clk); while (!s_tready);
        queue_step(act, val, !typed);
        if (typed)
            expect_q.push_back(res);
    endtask

    task automatic wait_empty();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (expect_q.size() != 0);
    endtask

    task automatic run_random(input int n);
        int    r;
        bit    fill_bias;
        logic [cfq_pkg::ACTION_BITS-1:0] act;
        fill_bias = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            // pick fill-heavy or drain-heavy runs at random so full and empty both recur
            if (i % 32 == 0)
                fill_bias = $urandom_range(1);
            r = $urandom_range(99);
            if (r < (fill_bias ? 55 : 25))
                act = cfq_pkg::ACT_APPEND;
            else if (r < (fill_bias ? 75 : 70))
                act = cfq_pkg::ACT_SERVE;
            else if (r < 80)
                act = cfq_pkg::ACT_SIZE;
            else if (r < 83)
                act = cfq_pkg::ACT_CLEAR;
            else if (r < 93)
                act = cfq_pkg::ACT_TRAVERSE;
            else
                act = 3'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
            send_action(act, $urandom, 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        beat_t got;
        beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tuser, m_tdata[31:0], m_tdata[36:32], m_tlast};
            if (expect_q.size() == 0)
                report_beat("unexpected beat", '0, got);
            else
            begin
                want = expect_q.pop_front();
                if (got !== want)
                    report_beat("mismatch", want, got);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        dir_tab = '{
            '{cfq_pkg::ACT_SERVE,    32'h0,        1,  1'b1,
              '{cfq_pkg::ST_EMPTY, 32'h0, 5'd0,  1'b1}},
            '{cfq_pkg::ACT_SIZE,     32'h0,        1,  1'b1,
              '{cfq_pkg::ST_EMPTY, 32'h0, 5'd0,  1'b1}},
            '{cfq_pkg::ACT_CLEAR,    32'h0,        1,  1'b1,
              '{cfq_pkg::ST_EMPTY, 32'h0, 5'd0,  1'b1}},
            '{cfq_pkg::ACT_TRAVERSE, 32'h0,        1,  1'b1,
              '{cfq_pkg::ST_EMPTY, 32'h0, 5'd0,  1'b1}},
            '{ACT_SPARE_LO,          32'hFFFFFFFF, 1,  1'b1,
              '{cfq_pkg::ST_OK,    32'h0, 5'd0,  1'b1}},
            '{ACT_SPARE_HI,          32'h0,        1,  1'b1,
              '{cfq_pkg::ST_OK,    32'h0, 5'd0,  1'b1}},
            '{cfq_pkg::ACT_APPEND,   32'h0,        1,  1'b1,
              '{cfq_pkg::ST_OK,    32'h0, 5'd1,  1'b1}},
            '{cfq_pkg::ACT_APPEND,   32'hFFFFFFFF, 1,  1'b1,
              '{cfq_pkg::ST_OK,    32'h0, 5'd2,  1'b1}},
            '{cfq_pkg::ACT_TRAVERSE, 32'h0,        1,  1'b0, '0},
            '{cfq_pkg::ACT_APPEND,   32'h0,        14, 1'b0, '0},
            '{cfq_pkg::ACT_APPEND,   32'hA5A5A5A5, 1,  1'b1,
              '{cfq_pkg::ST_FULL,  32'h0, 5'd16, 1'b1}},
            '{cfq_pkg::ACT_TRAVERSE, 32'h0,        1,  1'b0, '0},
            '{cfq_pkg::ACT_SERVE,    32'h0,        1,  1'b0, '0},
            '{cfq_pkg::ACT_APPEND,   32'h5A5A5A5A, 1,  1'b0, '0},
            '{ACT_SPARE_MID,         32'h0,        1,  1'b1,
              '{cfq_pkg::ST_OK,    32'h0, 5'd16, 1'b1}},
            '{cfq_pkg::ACT_CLEAR,    32'h0,        1,  1'b1,
              '{cfq_pkg::ST_OK,    32'h0, 5'd0,  1'b1}},
            '{cfq_pkg::ACT_SERVE,    32'h0,        1,  1'b1,
              '{cfq_pkg::ST_EMPTY, 32'h0, 5'd0,  1'b1}}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 15;
        recv_idle_pct = 57;
        foreach (dir_tab[i])
        begin
            for (int k = 0; k < dir_tab[i].reps; k++)
                send_action(dir_tab[i].act, (dir_tab[i].reps > 1) ? $urandom : dir_tab[i].val,
                            dir_tab[i].typed, dir_tab[i].res);
        end
        run_random(PHASE_ITEMS);
        wait_empty();

        send_idle_pct = 57;
        recv_idle_pct = 15;
        run_random(PHASE_ITEMS);
        wait_empty();

        // no idling; receiver holds off long enough for the queue to back up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_left = LONG_STALL;
        run_random(PHASE_ITEMS);
        wait_empty();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0 && expect_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
